@@ rtl/quadratic_nonneg_root_solver_defines.svh @@
// assertion macros for the quadratic root solver
`ifndef QUADRATIC_NONNEG_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_NONNEG_ROOT_SOLVER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define QRS_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// implication whose consequent is checked in the cycle after the antecedent
`define QRS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

@@ rtl/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg
// shared constants, status codes and pipeline types of the quadratic solver
// ----------------------------------------------------------------------------
`default_nettype none
package qrs_pkg;
	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int STATUS_W      = 3;
	localparam int REG_IDX_W     = 2;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NEG_DISC = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_ROOT  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_A_ZERO   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SAT      = 3'd4;

	localparam logic [REG_IDX_W-1:0] REG_SQUARE   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_LINEAR   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CONSTANT = 2'd2;

	// control that travels along the cell chain with an item
	typedef struct packed {
		logic                valid;
		logic                done;
		logic [STATUS_W-1:0] status;
	} ctl_t;
endpackage
`default_nettype wire

@@ rtl/qrs_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// one digit of a restoring square root over a pipelined chain
// ----------------------------------------------------------------------------
`default_nettype none
module qrs_sqrt_cell
	import qrs_pkg::*;
#(
	parameter int DW = 128,
	parameter int RW = 64,
	parameter int STEP = 0,
	parameter int PW = 32
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire ctl_t          ctl_in,
	input  wire logic [DW-1:0] rem_in,
	input  wire logic [RW-1:0] root_in,
	input  wire logic [PW-1:0] pass_in,
	output ctl_t               ctl_out,
	output logic [DW-1:0]      rem_out,
	output logic [RW-1:0]      root_out,
	output logic [PW-1:0]      pass_out
);
	localparam int SH = 2 * (RW - 1 - STEP);
	logic [DW+1:0] trial;
	logic [DW+1:0] rem_sh;
	logic          take;

	always_comb begin
		trial  = ({{(DW+2-RW){1'b0}}, root_in} << 2 | {{(DW+1){1'b0}}, 1'b1}) << SH;
		rem_sh = {2'b00, rem_in};
		take   = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= take ? DW'(rem_sh - trial) : rem_in;
			root_out <= {root_in[RW-2:0], take};
			pass_out <= pass_in;
		end
	end
endmodule
`default_nettype wire

@@ rtl/qrs_div_cell.sv @@
// ----------------------------------------------------------------------------
// qrs_div_cell
// one quotient bit of a restoring division over a pipelined chain
// ----------------------------------------------------------------------------
`default_nettype none
module qrs_div_cell
	import qrs_pkg::*;
#(
	parameter int NW = 80,
	parameter int DVW = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire ctl_t           ctl_in,
	input  wire logic [NW-1:0]  num_in,
	input  wire logic [DVW:0]   rem_in,
	input  wire logic [DVW-1:0] den_in,
	output ctl_t                ctl_out,
	output logic [NW-1:0]       num_out,
	output logic [DVW:0]        rem_out,
	output logic [DVW-1:0]      den_out
);
	logic [DVW+1:0] r2;
	logic           take;

	always_comb begin
		r2   = {rem_in, num_in[NW-1]};
		take = r2 >= {2'b00, den_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	// quotient bits shift into the low end of the numerator word
	always_ff @(posedge clk) begin
		if (en) begin
			rem_out <= take ? (DVW+1)'(r2 - {2'b00, den_in}) : r2[DVW:0];
			num_out <= {num_in[NW-2:0], take};
			den_out <= den_in;
		end
	end
endmodule
`default_nettype wire

@@ rtl/quadratic_nonneg_root_solver.sv @@
// ----------------------------------------------------------------------------
// quadratic_nonneg_root_solver
// nonnegative root of a*x^2+b*x+c=y in signed fixed point
// ----------------------------------------------------------------------------
// channel | signals                                   | direction
// cfg     | cfg_valid cfg_ready cfg_index cfg_data   | in
// in      | in_valid in_ready target_value           | in
// out     | out_valid out_ready root_value status    | out
// one item enters per cycle unless the output is held; the pipeline is made of:
// three front stages, WORD_BITS+2 square root cells, a select stage,
// WORD_BITS+2+FRAC_BITS divider cells and the output register
// the whole chain advances together and freezes when the output is held
// reset clears the coefficients and all valid flags
`default_nettype none
module quadratic_nonneg_root_solver
	import qrs_pkg::*;
#(
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [REG_IDX_W-1:0]        cfg_index,
	input  wire logic [WORD_BITS-1:0]        cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [WORD_BITS-1:0] target_value,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [WORD_BITS-1:0]      root_value,
	output logic [STATUS_W-1:0]              status
);
	localparam int W   = WORD_BITS;
	localparam int DW  = 2 * W + 4;       // discriminant width
	localparam int RW  = DW / 2;          // square root width
	localparam int NUW = W + 2;           // numerator magnitude width
	localparam int NW  = NUW + FRAC_BITS; // shifted numerator width
	localparam int DVW = W + 1;           // 2|a| width

	logic [W-1:0] a_q, b_q, c_q;
	logic en;
	assign en = !out_valid || out_ready;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			c_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SQUARE:   a_q <= cfg_data;
				REG_LINEAR:   b_q <= cfg_data;
				REG_CONSTANT: c_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: c - y and the coefficients
	logic signed [W:0] cy_s1;
	logic [W-1:0] a_s1, b_s1;
	ctl_t ctl_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s1 <= '0;
		else if (en) ctl_s1 <= '{valid: in_valid, done: 1'b0, status: ST_OK};
	end
	always_ff @(posedge clk) begin
		if (en) begin
			cy_s1 <= $signed({c_q[W-1], c_q}) - $signed({target_value[W-1], target_value});
			a_s1  <= a_q;
			b_s1  <= b_q;
		end
	end

	// stage 2: magnitudes and products
	logic [2*W-1:0] bb_s2;
	logic [2*W:0]   acy_s2;
	logic           tneg_s2;
	logic [W-1:0]   a_s2, b_s2;
	ctl_t ctl_s2;
	logic [W-1:0] ma1, mb1;
	logic [W:0]   mcy1;
	always_comb begin
		ma1  = a_s1[W-1] ? W'(-a_s1) : a_s1;
		mb1  = b_s1[W-1] ? W'(-b_s1) : b_s1;
		mcy1 = cy_s1[W] ? (W+1)'(-cy_s1) : cy_s1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s2 <= '0;
		else if (en) ctl_s2 <= ctl_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			bb_s2   <= mb1 * mb1;
			acy_s2  <= (2*W+1)'(ma1 * mcy1);
			tneg_s2 <= a_s1[W-1] ^ cy_s1[W];
			a_s2    <= a_s1;
			b_s2    <= b_s1;
		end
	end

	// stage 3: discriminant and status
	logic [DW-1:0] d_s3;
	logic [W-1:0]  a_s3, b_s3;
	ctl_t ctl_s3;
	ctl_t ctl_nx3;
	logic [DW-1:0] t2, bbw;
	logic [DW:0]   dsum;
	logic          tzero;
	always_comb begin
		t2    = {1'b0, acy_s2, 2'b00};
		bbw   = {4'b0, bb_s2};
		tzero = (acy_s2 == '0);
		dsum  = (tneg_s2 && !tzero) ? {1'b0, bbw} + {1'b0, t2} : {1'b0, bbw} - {1'b0, t2};
	end
	always_comb begin
		ctl_nx3 = ctl_s2;
		if (!(tneg_s2 && !tzero) && (bbw < t2)) begin
			ctl_nx3.done   = 1'b1;
			ctl_nx3.status = ST_NEG_DISC;
		end else if (a_s2 == '0) begin
			ctl_nx3.done   = 1'b1;
			ctl_nx3.status = ST_A_ZERO;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s3 <= ctl_nx3;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			d_s3 <= dsum[DW-1:0];
			a_s3 <= a_s2;
			b_s3 <= b_s2;
		end
	end

	// square root chain
	ctl_t          sc [RW+1];
	logic [DW-1:0] sr [RW+1];
	logic [RW-1:0] sq [RW+1];
	logic [2*W-1:0] sp [RW+1];
	assign sc[0] = ctl_s3;
	assign sr[0] = d_s3;
	assign sq[0] = '0;
	assign sp[0] = {a_s3, b_s3};
	for (genvar g = 0; g < RW; g++) begin : g_sqrt
		qrs_sqrt_cell #(.DW(DW), .RW(RW), .STEP(g), .PW(2*W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.ctl_in(sc[g]), .rem_in(sr[g]), .root_in(sq[g]), .pass_in(sp[g]),
			.ctl_out(sc[g+1]), .rem_out(sr[g+1]), .root_out(sq[g+1]), .pass_out(sp[g+1])
		);
	end

	// stage 4: root selection
	logic [W-1:0]   a_f, b_f;
	logic signed [NUW-1:0] p4, m4, sb;
	logic pos_ok, neg_ok;
	assign a_f = sp[RW][2*W-1:W];
	assign b_f = sp[RW][W-1:0];
	always_comb begin
		sb = NUW'($signed(b_f));
		p4 = NUW'($signed({1'b0, sq[RW]})) - sb;
		m4 = -sb - NUW'($signed({1'b0, sq[RW]}));
		pos_ok = (p4 == '0) || ((p4 > 0) == !a_f[W-1]);
		neg_ok = (m4 == '0) || ((m4 > 0) == !a_f[W-1]);
	end
	ctl_t ctl_s4;
	ctl_t ctl_nx4;
	logic [NW-1:0]  num_s4;
	logic [DVW-1:0] den_s4;
	logic signed [NUW-1:0] sel;
	always_comb sel = pos_ok ? p4 : m4;
	always_comb begin
		ctl_nx4 = sc[RW];
		if (!sc[RW].done && !pos_ok && !neg_ok) begin
			ctl_nx4.done   = 1'b1;
			ctl_nx4.status = ST_NO_ROOT;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_nx4;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			num_s4 <= {(sel[NUW-1] ? NUW'(-sel) : sel), {FRAC_BITS{1'b0}}};
			den_s4 <= {(a_f[W-1] ? W'(-a_f) : a_f), 1'b0};
		end
	end

	// divider chain
	ctl_t           dc [NW+1];
	logic [NW-1:0]  dn [NW+1];
	logic [DVW:0]   dr [NW+1];
	logic [DVW-1:0] dd [NW+1];
	assign dc[0] = ctl_s4;
	assign dn[0] = num_s4;
	assign dr[0] = '0;
	assign dd[0] = den_s4;
	for (genvar g = 0; g < NW; g++) begin : g_div
		qrs_div_cell #(.NW(NW), .DVW(DVW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.ctl_in(dc[g]), .num_in(dn[g]), .rem_in(dr[g]), .den_in(dd[g]),
			.ctl_out(dc[g+1]), .num_out(dn[g+1]), .rem_out(dr[g+1]), .den_out(dd[g+1])
		);
	end

	// output register
	logic sat;
	assign sat = (dn[NW] >> (W - 1)) != '0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			status    <= ST_OK;
			root_value <= '0;
		end else if (en) begin
			out_valid <= dc[NW].valid;
			if (dc[NW].done) begin
				status     <= dc[NW].status;
				root_value <= '0;
			end else if (sat) begin
				status     <= ST_SAT;
				root_value <= {1'b0, {(W-1){1'b1}}};
			end else begin
				status     <= ST_OK;
				root_value <= dn[NW][W-1:0];
			end
		end
	end
endmodule
`default_nettype wire

@@ rtl/qrs_checker.sv @@
// ----------------------------------------------------------------------------
// qrs_checker
// port level checks of the quadratic solver
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadratic_nonneg_root_solver_defines.svh"
module qrs_checker
	import qrs_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [31:0]         root_value,
	input wire logic [STATUS_W-1:0] status
);
	`QRS_ASSERT_IMP(a_status_range, clk, arst_n, out_valid, status <= ST_SAT)
	`QRS_ASSERT_IMP(a_zero_on_err, clk, arst_n,
		out_valid && (status == ST_NEG_DISC || status == ST_NO_ROOT || status == ST_A_ZERO),
		root_value == '0)
	`QRS_ASSERT_IMP(a_nonneg, clk, arst_n, out_valid, !root_value[31])
	`QRS_ASSERT_IMP(a_ready_free, clk, arst_n, !out_valid || out_ready, in_ready)
	`QRS_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(root_value))
endmodule
bind quadratic_nonneg_root_solver qrs_checker u_qrs_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready), .out_valid(out_valid),
	.out_ready(out_ready), .root_value(root_value), .status(status)
);
`default_nettype wire
